// ===== rtl/core/plm_pkg.sv =====
`default_nettype none

package plm_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  localparam int CMD_W     = 3;
  localparam int POS_W     = 6;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_READ   = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_CLEAR  = 3'd4
  } plm_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2
  } plm_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_PRIME,
    ST_INS_SHIFT,
    ST_INS_PUT,
    ST_RM_PRIME,
    ST_RM_SHIFT,
    ST_READ_WAIT,
    ST_DONE
  } plm_state_t;

  typedef enum logic [2:0] {
    AS_POS,
    AS_IDX,
    AS_IDX_DN,
    AS_IDX_DN2,
    AS_IDX_UP
  } plm_asel_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value_in;
  } plm_req_t;

  typedef struct packed {
    logic [VAL_W-1:0]     value_out;
    logic [STAT_W-1:0]    status;
    logic [CNT_OUT_W-1:0] count;
  } plm_rsp_t;

  typedef struct packed {
    logic      req_load;
    logic      stat_load;
    logic      idx_ins;
    logic      idx_rm;
    logic      idx_dec;
    logic      idx_inc;
    logic      rd_en;
    plm_asel_t rd_sel;
    logic      rd_capture;
    logic      wr_en;
    plm_asel_t wr_sel;
    logic      wd_val;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      cnt_clr;
    logic      out_load;
  } plm_ctl_t;

  typedef struct packed {
    plm_cmd_t cmd;
    logic     ok;
    logic     ins_shift;
    logic     rm_shift;
    logic     ins_more;
    logic     rm_more;
    logic     out_busy;
  } plm_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/plm_ram.sv =====
`default_nettype none

module plm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/plm_ctrl.sv =====
`default_nettype none

module plm_ctrl
  import plm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire plm_sts_t sts,
  output plm_ctl_t      ctl
);

  plm_state_t state_r;
  plm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!sts.ok) begin
          state_nxt = ST_DONE;
        end else begin
          case (sts.cmd)
            CMD_INSERT: state_nxt = sts.ins_shift ? ST_INS_PRIME : ST_INS_PUT;
            CMD_REMOVE: state_nxt = sts.rm_shift ? ST_RM_PRIME : ST_DONE;
            CMD_READ:   state_nxt = ST_READ_WAIT;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_INS_PRIME: state_nxt = ST_INS_SHIFT;
      ST_INS_SHIFT: begin
        if (!sts.ins_more) begin
          state_nxt = ST_INS_PUT;
        end
      end
      ST_INS_PUT:   state_nxt = ST_DONE;
      ST_RM_PRIME:  state_nxt = ST_RM_SHIFT;
      ST_RM_SHIFT: begin
        if (!sts.rm_more) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ_WAIT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall     = 1'b0;
        ctl.req_load = in_valid;
      end
      ST_DECODE: begin
        ctl.stat_load = 1'b1;
        if (sts.ok) begin
          case (sts.cmd)
            CMD_INSERT: ctl.idx_ins = sts.ins_shift;
            CMD_REMOVE: begin
              ctl.idx_rm  = sts.rm_shift;
              ctl.cnt_dec = !sts.rm_shift;
            end
            CMD_READ: begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = AS_POS;
            end
            CMD_WRITE: begin
              ctl.wr_en  = 1'b1;
              ctl.wr_sel = AS_POS;
              ctl.wd_val = 1'b1;
            end
            CMD_CLEAR: ctl.cnt_clr = 1'b1;
            default: ;
          endcase
        end
      end
      ST_INS_PRIME: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = AS_IDX_DN;
      end
      ST_INS_SHIFT: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = AS_IDX;
        if (sts.ins_more) begin
          ctl.rd_en   = 1'b1;
          ctl.rd_sel  = AS_IDX_DN2;
          ctl.idx_dec = 1'b1;
        end
      end
      ST_INS_PUT: begin
        ctl.wr_en   = 1'b1;
        ctl.wr_sel  = AS_POS;
        ctl.wd_val  = 1'b1;
        ctl.cnt_inc = 1'b1;
      end
      ST_RM_PRIME: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = AS_IDX;
      end
      ST_RM_SHIFT: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = AS_IDX_DN;
        if (sts.rm_more) begin
          ctl.rd_en   = 1'b1;
          ctl.rd_sel  = AS_IDX_UP;
          ctl.idx_inc = 1'b1;
        end else begin
          ctl.cnt_dec = 1'b1;
        end
      end
      ST_READ_WAIT: ctl.rd_capture = 1'b1;
      ST_DONE:      ctl.out_load = !sts.out_busy;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_DECODE))
    else $error("accepted request did not move to decode");

  a_done_returns: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |=> (state_r == ST_IDLE))
    else $error("result load did not return to idle");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/plm_dp.sv =====
`default_nettype none

module plm_dp
  import plm_pkg::*;
#(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int DATA_W = DATA_W_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire plm_req_t in_data,
  output plm_rsp_t      out_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire plm_ctl_t ctl,
  output plm_sts_t      sts
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  plm_req_t    req_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] idx_nxt;
  plm_status_t stat_r;
  plm_status_t stat_nxt;
  logic [DATA_W-1:0] rdv_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  plm_rsp_t    out_data_r;

  logic [CMPW-1:0] posx;
  logic [CMPW-1:0] cntx;
  logic [CMPW-1:0] idxx;
  logic            bad_ins;
  logic            bad_acc;
  logic            full;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [DATA_W-1:0] rd_data;

  function automatic logic [AW-1:0] sel_addr(plm_asel_t sel, logic [CMPW-1:0] p,
                                             logic [CW-1:0] idx);
    logic [AW-1:0] a;
    case (sel)
      AS_POS:     a = AW'(p - CMPW'(1));
      AS_IDX:     a = AW'(idx);
      AS_IDX_DN:  a = AW'(idx - CW'(1));
      AS_IDX_DN2: a = AW'(idx - CW'(2));
      AS_IDX_UP:  a = AW'(idx + CW'(1));
      default:    a = AW'(idx);
    endcase
    return a;
  endfunction

  assign posx    = CMPW'(req_r.position);
  assign cntx    = CMPW'(count_r);
  assign idxx    = CMPW'(idx_r);
  assign bad_ins = (posx == '0) || (posx > cntx + CMPW'(1));
  assign bad_acc = (posx == '0) || (posx > cntx);
  assign full    = (cntx >= CMPW'(DEPTH));

  always_comb begin
    case (req_r.cmd)
      CMD_INSERT: stat_nxt = bad_ins ? STAT_BADPOS : (full ? STAT_FULL : STAT_OK);
      CMD_REMOVE,
      CMD_READ,
      CMD_WRITE:  stat_nxt = bad_acc ? STAT_BADPOS : STAT_OK;
      default:    stat_nxt = STAT_OK;
    endcase
  end

  assign sts.cmd       = plm_cmd_t'(req_r.cmd);
  assign sts.ok        = (stat_nxt == STAT_OK);
  assign sts.ins_shift = (posx <= cntx);
  assign sts.rm_shift  = (posx < cntx);
  assign sts.ins_more  = (idxx > posx);
  assign sts.rm_more   = ((idxx + CMPW'(1)) < cntx);
  assign sts.out_busy  = out_valid_r && out_stall;

  assign rd_addr = sel_addr(ctl.rd_sel, posx, idx_r);
  assign wr_addr = sel_addr(ctl.wr_sel, posx, idx_r);
  assign wr_data = ctl.wd_val ? DATA_W'(req_r.value_in) : rd_data;

  plm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    count_nxt = count_r;
    if (ctl.cnt_clr) begin
      count_nxt = '0;
    end else if (ctl.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (ctl.idx_ins) begin
      idx_nxt = count_r;
    end else if (ctl.idx_rm) begin
      idx_nxt = CW'(posx);
    end else if (ctl.idx_dec) begin
      idx_nxt = idx_r - CW'(1);
    end else if (ctl.idx_inc) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  assign out_valid_nxt = ctl.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (ctl.req_load) begin
      req_r <= in_data;
    end
    if (ctl.stat_load) begin
      stat_r <= stat_nxt;
      rdv_r  <= '0;
    end else if (ctl.rd_capture) begin
      rdv_r <= rd_data;
    end
    if (ctl.out_load) begin
      out_data_r.value_out <= VAL_W'(rdv_r);
      out_data_r.status    <= stat_r;
      out_data_r.count     <= CNT_OUT_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cntx <= CMPW'(DEPTH))
    else $error("entry count exceeds depth");

  a_load_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  a_capture_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd_capture |-> $past(ctl.rd_en))
    else $error("read data captured without a read");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/positional_list_engine.sv =====
// Ordered list of up to DEPTH entries addressed by 1-based position, one request at a
// time. A request is taken only while the engine is idle; its result lands in an output
// register, so the next request may be taken while that result still waits. An insert
// at position p first moves the entries from p onward one place up, and a remove at
// position p moves the entries after p one place down (neither moves any when it
// appends at the end or drops the last entry); the entries move one per cycle
// through the single read and single write port of the entry RAM. Entries never
// written are never returned, since only positions within the current length are read.
`default_nettype none

module positional_list_engine
  import plm_pkg::*;
#(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int DATA_W = DATA_W_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire plm_req_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output plm_rsp_t      out_data
);

  plm_ctl_t ctl;
  plm_sts_t sts;

  plm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  plm_dp #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

`default_nettype wire
